// File: hw/rtl/bgss_pkg.sv
// Shared types, codes and helpers for the bilinear grid sample/splat block.
// No dependencies; every other file but bgss_ram refers to this package by scoped names.
`timescale 1ns / 1ps
package bgss_pkg;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_SAMPLE  = 2'd2,
      OP_DEPOSIT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ISSUE,
      BK_MODIFY,
      BK_FINISH
   } back_state_type;

   localparam int VALUE_W     = 32;
   localparam int DIM_W       = 8;
   localparam int COORD_W     = 7;
   localparam int FRAC_IN_W   = 16;
   localparam int TERM_W      = VALUE_W + 1;
   localparam int SUM_W       = VALUE_W + 3;
   localparam int NEIGHBORS   = 4;
   localparam int IDX_W       = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_INDEX_W = 2;

   localparam logic [IDX_W-1:0]       LAST_IDX     = 2'd3;
   localparam logic [DIM_W-1:0]       DIM_RESET    = 8'd128;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT   = 2'd1;

   // Fixed part of one queued work word.
   typedef struct packed {
      op_type                     op;
      logic                       err;
      logic signed [VALUE_W-1:0]  value;
   } item_ctrl_type;

   function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [VALUE_W-1:0] r;
      if (v > SUM_W'(signed'({1'b0, {(VALUE_W-1){1'b1}}}))) begin
         r = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (v < SUM_W'(signed'({1'b1, {(VALUE_W-1){1'b0}}}))) begin
         r = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         r = v[VALUE_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/bgss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module bgss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] cells_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/bgss_queue.sv
// Short FIFO that decouples the classify front end from the memory back end.
// Uses bgss_pkg for its depth.
`timescale 1ns / 1ps
module bgss_queue #(
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output logic [DATA_W-1:0] pop_data
);
   localparam int DEPTH = bgss_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   push_not_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("word pushed into full queue");

   pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("word popped from empty queue");

   count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");
endmodule

// File: hw/rtl/bgss_front.sv
// Front end: takes a command word, checks range, forms the four cell
// addresses and bilinear weights, and hands the work word on. Uses bgss_pkg.
`timescale 1ns / 1ps
module bgss_front #(
   parameter int FRAC_BITS = 16,
   parameter int ADDR_W    = 14
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_opcode,
   input  logic [bgss_pkg::COORD_W-1:0]           req_x_whole,
   input  logic [bgss_pkg::COORD_W-1:0]           req_y_whole,
   input  logic [bgss_pkg::FRAC_IN_W-1:0]         req_x_frac,
   input  logic [bgss_pkg::FRAC_IN_W-1:0]         req_y_frac,
   input  logic signed [bgss_pkg::VALUE_W-1:0]    req_value_in,
   input  logic [bgss_pkg::DIM_W-1:0]             width_in_use,
   input  logic [bgss_pkg::DIM_W-1:0]             height_in_use,
   input  logic                                   push_ready,
   output logic                                   push_valid,
   output bgss_pkg::item_ctrl_type                push_ctrl,
   output logic [bgss_pkg::NEIGHBORS-1:0][ADDR_W-1:0]    push_addr,
   output logic [bgss_pkg::NEIGHBORS-1:0][FRAC_BITS:0]   push_wt
);
   localparam int WT_W  = FRAC_BITS + 1;
   localparam int DIM_W = bgss_pkg::DIM_W;
   localparam int ROW_W = 2 * DIM_W + 1;
   localparam logic [WT_W-1:0] ONE_Q = WT_W'(1) << FRAC_BITS;

   logic                                  stg_valid_ff, stg_valid_in;
   bgss_pkg::op_type                      stg_op_ff;
   logic [bgss_pkg::COORD_W-1:0]          stg_x_ff, stg_y_ff;
   logic [bgss_pkg::FRAC_IN_W-1:0]        stg_fx_ff, stg_fy_ff;
   logic signed [bgss_pkg::VALUE_W-1:0]   stg_value_ff;

   logic              accept;
   logic [DIM_W-1:0]  x_ext, y_ext, x_next, y_next, x1, y1;
   logic [2*DIM_W-1:0] row0, row1;
   logic [FRAC_BITS-1:0] fx, fy;
   logic [WT_W-1:0]   wx0, wx1, wy0, wy1;
   logic [2*WT_W-1:0] p00, p10, p01, p11;

   assign busy         = stg_valid_ff && !push_ready;
   assign accept       = start && !busy;
   assign stg_valid_in = accept || busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
      if (accept) begin
         stg_op_ff    <= bgss_pkg::op_type'(req_opcode);
         stg_x_ff     <= req_x_whole;
         stg_y_ff     <= req_y_whole;
         stg_fx_ff    <= req_x_frac;
         stg_fy_ff    <= req_y_frac;
         stg_value_ff <= req_value_in;
      end
   end

   // Clamp the second neighbour onto the first at the right and bottom edges.
   always_comb begin
      x_ext  = {1'b0, stg_x_ff};
      y_ext  = {1'b0, stg_y_ff};
      x_next = x_ext + 1'b1;
      y_next = y_ext + 1'b1;
      x1     = (x_next < width_in_use)  ? x_next : x_ext;
      y1     = (y_next < height_in_use) ? y_next : y_ext;
      row0   = y_ext * width_in_use;
      row1   = y1 * width_in_use;
   end

   always_comb begin
      fx  = FRAC_BITS'(stg_fx_ff);
      fy  = FRAC_BITS'(stg_fy_ff);
      wx1 = {1'b0, fx};
      wy1 = {1'b0, fy};
      wx0 = ONE_Q - wx1;
      wy0 = ONE_Q - wy1;
      p00 = wx0 * wy0;
      p10 = wx1 * wy0;
      p01 = wx0 * wy1;
      p11 = wx1 * wy1;
   end

   assign push_valid      = stg_valid_ff;
   assign push_ctrl.op    = stg_op_ff;
   assign push_ctrl.err   = (x_ext >= width_in_use) || (y_ext >= height_in_use);
   assign push_ctrl.value = stg_value_ff;

   assign push_addr[0] = ADDR_W'(ROW_W'(row0) + ROW_W'(x_ext));
   assign push_addr[1] = ADDR_W'(ROW_W'(row0) + ROW_W'(x1));
   assign push_addr[2] = ADDR_W'(ROW_W'(row1) + ROW_W'(x_ext));
   assign push_addr[3] = ADDR_W'(ROW_W'(row1) + ROW_W'(x1));

   assign push_wt[0] = WT_W'(p00 >> FRAC_BITS);
   assign push_wt[1] = WT_W'(p10 >> FRAC_BITS);
   assign push_wt[2] = WT_W'(p01 >> FRAC_BITS);
   assign push_wt[3] = WT_W'(p11 >> FRAC_BITS);
endmodule

// File: hw/rtl/bgss_back.sv
// Back end: runs one work word at a time against the grid memory through a
// single port and drives the result word. Uses bgss_pkg and bgss_ram.
`timescale 1ns / 1ps
module bgss_back #(
   parameter int FRAC_BITS = 16,
   parameter int DEPTH     = 16384
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           pop_valid,
   output logic                                           pop,
   input  bgss_pkg::item_ctrl_type                        pop_ctrl,
   input  logic [bgss_pkg::NEIGHBORS-1:0][$clog2(DEPTH)-1:0] pop_addr,
   input  logic [bgss_pkg::NEIGHBORS-1:0][FRAC_BITS:0]    pop_wt,
   output logic                                           rsp_strobe,
   output logic signed [bgss_pkg::VALUE_W-1:0]            rsp_value_out,
   output logic                                           rsp_status
);
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int WT_W    = FRAC_BITS + 1;
   localparam int VALUE_W = bgss_pkg::VALUE_W;
   localparam int TERM_W  = bgss_pkg::TERM_W;
   localparam int SUM_W   = bgss_pkg::SUM_W;
   localparam int PROD_W  = VALUE_W + WT_W + 1;

   bgss_pkg::back_state_type state_ff, state_in;
   bgss_pkg::item_ctrl_type  cur_ctrl_ff, cur_ctrl_in;
   logic [bgss_pkg::NEIGHBORS-1:0][ADDR_W-1:0] cur_addr_ff, cur_addr_in;
   logic [bgss_pkg::NEIGHBORS-1:0][WT_W-1:0]   cur_wt_ff, cur_wt_in;
   logic [bgss_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic signed [TERM_W-1:0]    term_ff, term_in;
   logic signed [TERM_W-1:0]    prod_ff, prod_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic signed [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                        rsp_status_ff, rsp_status_in;

   logic                      ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]         ram_addr;
   logic [VALUE_W-1:0]        ram_wr_data, ram_rd_data;
   logic signed [VALUE_W-1:0] mul_a;
   logic signed [WT_W:0]      mul_b;
   logic signed [PROD_W-1:0]  mul_full;
   logic signed [TERM_W-1:0]  mul_term;
   logic signed [SUM_W-1:0]   dep_sum, final_sum;
   logic                      last_cell;

   bgss_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(DEPTH)
   ) u_grid (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_addr),
      .rd_data(ram_rd_data)
   );

   // One shared multiplier: delta times weight while issuing, cell times
   // weight once the read data is back. Taking the upper bits floors.
   always_comb begin
      mul_a     = (state_ff == bgss_pkg::BK_ISSUE) ? cur_ctrl_ff.value
                                                   : signed'(ram_rd_data);
      mul_b     = signed'({1'b0, cur_wt_ff[idx_ff]});
      mul_full  = mul_a * mul_b;
      mul_term  = mul_full[FRAC_BITS+TERM_W-1:FRAC_BITS];
      dep_sum   = SUM_W'(signed'(ram_rd_data)) + SUM_W'(term_ff);
      final_sum = sum_ff + SUM_W'(prod_ff);
      last_cell = (idx_ff == bgss_pkg::LAST_IDX);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bgss_pkg::BK_IDLE: begin
            if (pop_valid) begin
               state_in = bgss_pkg::BK_ISSUE;
            end
         end
         bgss_pkg::BK_ISSUE: begin
            if (cur_ctrl_ff.err || cur_ctrl_ff.op == bgss_pkg::OP_WRITE) begin
               state_in = bgss_pkg::BK_IDLE;
            end else begin
               state_in = bgss_pkg::BK_MODIFY;
            end
         end
         bgss_pkg::BK_MODIFY: begin
            if (cur_ctrl_ff.op == bgss_pkg::OP_READ) begin
               state_in = bgss_pkg::BK_IDLE;
            end else if (!last_cell) begin
               state_in = bgss_pkg::BK_ISSUE;
            end else if (cur_ctrl_ff.op == bgss_pkg::OP_SAMPLE) begin
               state_in = bgss_pkg::BK_FINISH;
            end else begin
               state_in = bgss_pkg::BK_IDLE;
            end
         end
         bgss_pkg::BK_FINISH: begin
            state_in = bgss_pkg::BK_IDLE;
         end
         default: begin
            state_in = bgss_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop           = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_addr      = cur_addr_ff[idx_ff];
      ram_wr_data   = cur_ctrl_ff.value;
      cur_ctrl_in   = cur_ctrl_ff;
      cur_addr_in   = cur_addr_ff;
      cur_wt_in     = cur_wt_ff;
      idx_in        = idx_ff;
      term_in       = term_ff;
      prod_in       = prod_ff;
      sum_in        = sum_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         bgss_pkg::BK_IDLE: begin
            pop         = pop_valid;
            cur_ctrl_in = pop_ctrl;
            cur_addr_in = pop_addr;
            cur_wt_in   = pop_wt;
            idx_in      = '0;
            sum_in      = '0;
         end
         bgss_pkg::BK_ISSUE: begin
            if (cur_ctrl_ff.err) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = 1'b1;
            end else if (cur_ctrl_ff.op == bgss_pkg::OP_WRITE) begin
               ram_wr_en     = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = 1'b0;
            end else begin
               ram_rd_en = 1'b1;
               term_in   = mul_term;
               if (idx_ff != '0) begin
                  sum_in = final_sum;
               end
            end
         end
         bgss_pkg::BK_MODIFY: begin
            case (cur_ctrl_ff.op)
               bgss_pkg::OP_READ: begin
                  rsp_strobe_in = 1'b1;
                  rsp_value_in  = signed'(ram_rd_data);
                  rsp_status_in = 1'b0;
               end
               bgss_pkg::OP_DEPOSIT: begin
                  // Write back before the next read so a clamped duplicate
                  // cell sees both terms.
                  ram_wr_en   = 1'b1;
                  ram_wr_data = bgss_pkg::sat32(dep_sum);
                  idx_in      = idx_ff + 1'b1;
                  if (last_cell) begin
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = 1'b0;
                  end
               end
               default: begin
                  prod_in = mul_term;
                  idx_in  = idx_ff + 1'b1;
               end
            endcase
         end
         bgss_pkg::BK_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = bgss_pkg::sat32(final_sum);
            rsp_status_in = 1'b0;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bgss_pkg::BK_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cur_ctrl_ff   <= cur_ctrl_in;
      cur_addr_ff   <= cur_addr_in;
      cur_wt_ff     <= cur_wt_in;
      idx_ff        <= idx_in;
      term_ff       <= term_in;
      prod_ff       <= prod_in;
      sum_ff        <= sum_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

   single_port_use: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("grid memory read and written in one cycle");

   strobe_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(state_ff) != bgss_pkg::BK_IDLE))
      else $error("result word without work in progress");

   finish_only_sample: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bgss_pkg::BK_FINISH) |->
         (cur_ctrl_ff.op == bgss_pkg::OP_SAMPLE && idx_ff == '0))
      else $error("finish reached outside a full sample");

   no_write_on_error: assert property (@(posedge clock) disable iff (reset)
      (state_ff != bgss_pkg::BK_IDLE && cur_ctrl_ff.err) |-> !ram_wr_en)
      else $error("out of range command touched the grid");
endmodule

// File: hw/rtl/bilinear_grid_sample_splat.sv
// Top level of the bilinear grid sample/splat block: size registers, front
// end, work queue and memory back end. Uses bgss_pkg, bgss_front,
// bgss_queue and bgss_back.
`timescale 1ns / 1ps
// A grid of signed Q16.16 cells (MAX_COLUMNS x MAX_ROWS, one memory,
// addressed row * width_in_use + column) takes four commands: write a cell,
// read a cell, bilinear sample around a fractional position, and bilinear
// deposit of a delta into the four neighbours (saturating). A command word
// is taken at a clock edge with start high and busy low; each command gives
// exactly one result word, shown for one cycle with rsp_strobe high and
// never held back, so the user must take it in that cycle. Results come in
// command order. A coordinate outside the configured size returns status 1
// and zero and leaves the grid alone. The front end takes a word, checks
// it and forms addresses and weights in the next cycle, then queues it
// (two entries); the back end owns the single memory port and runs one word
// at a time: write and errors end at issue, read issues then answers,
// deposit reads then writes back each of four cells, and sample makes four
// reads through one shared multiplier plus a final sum. That memory port
// sets the sustained rate; busy rises once the queue and the front register
// are both full. No clearing pass: cells are undefined until written, and
// reading one before that returns garbage. The user must write size registers
// through the csr_ channel (always ready) only while idle; the block does not
// enforce this. Zero acts as one; values past the maximum act as the maximum.
module bilinear_grid_sample_splat #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 128,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_opcode,
   input  logic [bgss_pkg::COORD_W-1:0]            req_x_whole,
   input  logic [bgss_pkg::COORD_W-1:0]            req_y_whole,
   input  logic [bgss_pkg::FRAC_IN_W-1:0]          req_x_frac,
   input  logic [bgss_pkg::FRAC_IN_W-1:0]          req_y_frac,
   input  logic signed [bgss_pkg::VALUE_W-1:0]     req_value_in,
   output logic                                    rsp_strobe,
   output logic signed [bgss_pkg::VALUE_W-1:0]     rsp_value_out,
   output logic                                    rsp_status,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [bgss_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [bgss_pkg::DIM_W-1:0]              csr_wdata
);
   localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int WT_W   = FRAC_BITS + 1;
   localparam int NB     = bgss_pkg::NEIGHBORS;
   localparam int WORD_W = $bits(bgss_pkg::item_ctrl_type) + NB * ADDR_W + NB * WT_W;

   // Zero acts as one; anything past the grid acts as the grid's edge.
   function automatic logic [bgss_pkg::DIM_W-1:0] clamp_dim(
      input logic [bgss_pkg::DIM_W-1:0] v,
      input int                         maxv
   );
      logic [bgss_pkg::DIM_W-1:0] r;
      r = (v == '0) ? bgss_pkg::DIM_W'(1) : v;
      if (int'(r) > maxv) begin
         r = bgss_pkg::DIM_W'(maxv);
      end
      return r;
   endfunction

   logic [bgss_pkg::DIM_W-1:0] width_ff, width_in;
   logic [bgss_pkg::DIM_W-1:0] height_ff, height_in;
   logic                       csr_write;

   logic                       push_valid, push_ready, push;
   bgss_pkg::item_ctrl_type    push_ctrl, pop_ctrl;
   logic [NB-1:0][ADDR_W-1:0]  push_addr, pop_addr;
   logic [NB-1:0][WT_W-1:0]    push_wt, pop_wt;
   logic [WORD_W-1:0]          push_word, pop_word;
   logic                       queue_full, queue_empty, pop;

   // Size registers: always ready, unknown indexes drop the word.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write && csr_index == bgss_pkg::CSR_WIDTH) begin
         width_in = clamp_dim(csr_wdata, MAX_COLUMNS);
      end
      if (csr_write && csr_index == bgss_pkg::CSR_HEIGHT) begin
         height_in = clamp_dim(csr_wdata, MAX_ROWS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_dim(bgss_pkg::DIM_RESET, MAX_COLUMNS);
         height_ff <= clamp_dim(bgss_pkg::DIM_RESET, MAX_ROWS);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   bgss_front #(
      .FRAC_BITS(FRAC_BITS),
      .ADDR_W   (ADDR_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_x_whole  (req_x_whole),
      .req_y_whole  (req_y_whole),
      .req_x_frac   (req_x_frac),
      .req_y_frac   (req_y_frac),
      .req_value_in (req_value_in),
      .width_in_use (width_ff),
      .height_in_use(height_ff),
      .push_ready   (push_ready),
      .push_valid   (push_valid),
      .push_ctrl    (push_ctrl),
      .push_addr    (push_addr),
      .push_wt      (push_wt)
   );

   // Pack the work word for the queue and unpack it on the far side.
   assign push_ready = !queue_full;
   assign push       = push_valid && push_ready;
   assign push_word  = {push_ctrl, push_addr, push_wt};
   assign {pop_ctrl, pop_addr, pop_wt} = pop_word;

   bgss_queue #(
      .DATA_W(WORD_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_word),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .pop_data (pop_word)
   );

   bgss_back #(
      .FRAC_BITS(FRAC_BITS),
      .DEPTH    (DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (!queue_empty),
      .pop          (pop),
      .pop_ctrl     (pop_ctrl),
      .pop_addr     (pop_addr),
      .pop_wt       (pop_wt),
      .rsp_strobe   (rsp_strobe),
      .rsp_value_out(rsp_value_out),
      .rsp_status   (rsp_status)
   );
endmodule

// File: test/bilinear_grid_sample_splat_checker.sv
// Checker for the bilinear grid sample/splat block: watches the command,
// result and size-register channels, predicts each result word and compares.
// Depends on bgss_pkg for the opcode enum and register indexes.
`timescale 1ns / 1ps
module bilinear_grid_sample_splat_checker #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [6:0]         req_x_whole,
   input  logic [6:0]         req_y_whole,
   input  logic [15:0]        req_x_frac,
   input  logic [15:0]        req_y_frac,
   input  logic signed [31:0] req_value_in,
   input  logic               rsp_strobe,
   input  logic signed [31:0] rsp_value_out,
   input  logic               rsp_status,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata,
   output int                 mismatch_count,
   output int                 results_due
);
   localparam int GRID_CELLS = MAX_COLUMNS * MAX_ROWS;
   localparam int FRAC_SHIFT = 16;

   typedef struct {
      logic signed [31:0] value;
      logic               status;
      int                 serial;
   } grid_result_type;

   logic signed [31:0] model_cells [GRID_CELLS];
   grid_result_type    due_results [$];
   int                 cols_in_use = MAX_COLUMNS;
   int                 rows_in_use = MAX_ROWS;
   int                 words_taken = 0;
   int                 mismatches  = 0;

   task automatic report_mismatch(input string what);
      $display("[%0t] checker: %s", $time, what);
      mismatches++;
   endtask

   function automatic int fit_dim(input logic [7:0] raw, input int limit);
      if (raw == 0) return 1;
      if (int'(raw) > limit) return limit;
      return int'(raw);
   endfunction

   function automatic logic signed [31:0] clip_to_word(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic int cell_index(input int x, input int y);
      return (y * cols_in_use + x) % GRID_CELLS;
   endfunction

   // Apply one command word to the grid copy and queue the word it must return.
   task automatic execute_command(input bgss_pkg::op_type op, input int x, input int y,
                                  input logic [15:0] fx, input logic [15:0] fy,
                                  input logic signed [31:0] delta);
      grid_result_type r;
      int              nx;
      int              ny;
      int              k;
      int              spot [4];
      longint          wt [4];
      longint          acc;
      logic [16:0]     ax0, ax1, ay0, ay1;
      r.value  = '0;
      r.status = 1'b0;
      r.serial = words_taken;
      if (x >= cols_in_use || y >= rows_in_use) begin
         r.status = 1'b1;
      end else begin
         // clamp the far neighbor onto the near one at the right and bottom edges
         nx = (x + 1 < cols_in_use) ? x + 1 : x;
         ny = (y + 1 < rows_in_use) ? y + 1 : y;
         spot[0] = cell_index(x, y);
         spot[1] = cell_index(nx, y);
         spot[2] = cell_index(x, ny);
         spot[3] = cell_index(nx, ny);
         ax1 = {1'b0, fx};
         ay1 = {1'b0, fy};
         ax0 = 17'h10000 - ax1;
         ay0 = 17'h10000 - ay1;
         wt[0] = (longint'(ax0) * longint'(ay0)) >>> FRAC_SHIFT;
         wt[1] = (longint'(ax1) * longint'(ay0)) >>> FRAC_SHIFT;
         wt[2] = (longint'(ax0) * longint'(ay1)) >>> FRAC_SHIFT;
         wt[3] = (longint'(ax1) * longint'(ay1)) >>> FRAC_SHIFT;
         case (op)
            bgss_pkg::OP_WRITE: begin
               model_cells[spot[0]] = delta;
            end
            bgss_pkg::OP_READ: begin
               r.value = model_cells[spot[0]];
            end
            bgss_pkg::OP_SAMPLE: begin
               acc = 0;
               for (k = 0; k < 4; k++) begin
                  acc += (longint'(model_cells[spot[k]]) * wt[k]) >>> FRAC_SHIFT;
               end
               r.value = clip_to_word(acc);
            end
            default: begin
               // deposit: nw, ne, sw, se in order, so a clamped cell takes every term
               for (k = 0; k < 4; k++) begin
                  model_cells[spot[k]] = clip_to_word(longint'(model_cells[spot[k]])
                                         + ((longint'(delta) * wt[k]) >>> FRAC_SHIFT));
               end
            end
         endcase
      end
      due_results.push_back(r);
   endtask

   always @(posedge clock) begin
      grid_result_type head;
      if (reset) begin
         cols_in_use = MAX_COLUMNS;
         rows_in_use = MAX_ROWS;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bgss_pkg::CSR_WIDTH:  cols_in_use = fit_dim(csr_wdata, MAX_COLUMNS);
               bgss_pkg::CSR_HEIGHT: rows_in_use = fit_dim(csr_wdata, MAX_ROWS);
               default:    ;
            endcase
         end
         // compare before queuing: a word taken at this edge cannot answer here
         if (rsp_strobe) begin
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("result word with nothing expected: value %h status %b",
                                         rsp_value_out, rsp_status));
            end else begin
               head = due_results.pop_front();
               if (rsp_status !== head.status) begin
                  report_mismatch($sformatf("word %0d status got %b expected %b",
                                            head.serial, rsp_status, head.status));
               end
               if (rsp_value_out !== head.value) begin
                  report_mismatch($sformatf("word %0d value_out got %h expected %h",
                                            head.serial, rsp_value_out, head.value));
               end
            end
         end
         if (start && !busy) begin
            execute_command(bgss_pkg::op_type'(req_opcode), int'(req_x_whole),
                            int'(req_y_whole), req_x_frac, req_y_frac, req_value_in);
            words_taken++;
         end
      end
      mismatch_count <= mismatches;
      results_due    <= due_results.size();
   end

endmodule

// File: test/bilinear_grid_sample_splat_tb.sv
// Top of the bilinear grid sample/splat testbench: clock, reset, stimulus
// and verdict. Depends on bgss_pkg, the block and the checker module.
`timescale 1ns / 1ps
module bilinear_grid_sample_splat_tb;

   localparam int GRID_COLUMNS = 128;
   localparam int GRID_ROWS    = 128;
   localparam int COORD_MAX    = 127;
   localparam int QUIET_LIMIT  = 2000;
   localparam int GAP_CAP      = 60;
   // indexes the block has no register behind; writes there must be ignored
   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_opcode;
   logic [6:0]         req_x_whole;
   logic [6:0]         req_y_whole;
   logic [15:0]        req_x_frac;
   logic [15:0]        req_y_frac;
   logic signed [31:0] req_value_in;
   logic               rsp_strobe;
   logic signed [31:0] rsp_value_out;
   logic               rsp_status;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [7:0]         csr_wdata;
   int                 mismatch_count;
   int                 results_due;

   // Stimulus-side view of the grid: the size in force and which memory
   // entries hold a written value. Read, sample and deposit all read cells,
   // so every cell they touch gets a write first.
   int cols;
   int rows;
   int idle_pct;
   int quiet_cycles = 0;
   bit written [GRID_COLUMNS * GRID_ROWS];

   // Per-phase size, sender idling and length of the random part.
   int phase_w [8]    = '{128, 6, 1, 255, 37, 2, 0, 128};
   int phase_h [8]    = '{128, 4, 128, 1, 200, 2, 0, 128};
   int phase_idle [8] = '{0, 82, 16, 0, 82, 16, 0, 16};
   int phase_len [8]  = '{30, 40, 30, 30, 30, 40, 30, 30};

   always #4 clock = ~clock;

   bilinear_grid_sample_splat #(
      .MAX_COLUMNS(GRID_COLUMNS),
      .MAX_ROWS   (GRID_ROWS),
      .FRAC_BITS  (16)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_x_whole  (req_x_whole),
      .req_y_whole  (req_y_whole),
      .req_x_frac   (req_x_frac),
      .req_y_frac   (req_y_frac),
      .req_value_in (req_value_in),
      .rsp_strobe   (rsp_strobe),
      .rsp_value_out(rsp_value_out),
      .rsp_status   (rsp_status),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   bilinear_grid_sample_splat_checker #(
      .MAX_COLUMNS(GRID_COLUMNS),
      .MAX_ROWS   (GRID_ROWS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_x_whole   (req_x_whole),
      .req_y_whole   (req_y_whole),
      .req_x_frac    (req_x_frac),
      .req_y_frac    (req_y_frac),
      .req_value_in  (req_value_in),
      .rsp_strobe    (rsp_strobe),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatch_count(mismatch_count),
      .results_due   (results_due)
   );

   // Watchdog: end the run once no command, result or register write is seen for too long.
   // A correct run never goes quiet for more than a sender gap plus a sample.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("bilinear_grid_sample_splat_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int eff_dim(input logic [7:0] raw, input int limit);
      if (raw == 0) return 1;
      if (int'(raw) > limit) return limit;
      return int'(raw);
   endfunction

   // Fractions: mostly random, with the corners of the weight range mixed in.
   function automatic logic [15:0] pick_frac();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Values: full-range random, saturation extremes, and small values that
   // let deposits accumulate without pinning at the rails.
   function automatic logic [31:0] pick_value();
      logic [31:0] bits;
      bits = $urandom;
      case ($urandom_range(0, 7))
         0:       return 32'h7FFFFFFF;
         1:       return 32'h80000000;
         2, 3, 4: return bits;
         default: return {{12{bits[19]}}, bits[19:0]};
      endcase
   endfunction

   // Send one command word: idle at random first, then hold start until the
   // block takes the word.
   task automatic issue(input bgss_pkg::op_type op, input int x, input int y,
                        input logic [15:0] fx, input logic [15:0] fy,
                        input logic [31:0] v);
      int gap;
      gap = 0;
      while (idle_pct > 0 && gap < GAP_CAP && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         gap++;
      end
      req_opcode   <= op;
      req_x_whole  <= x[6:0];
      req_y_whole  <= y[6:0];
      req_x_frac   <= fx;
      req_y_frac   <= fy;
      req_value_in <= v;
      start        <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      if (op == bgss_pkg::OP_WRITE && x < cols && y < rows) begin
         written[(y * cols + x) % (GRID_COLUMNS * GRID_ROWS)] = 1'b1;
      end
   endtask

   // Issue a command, writing random values into any cell it reads that has
   // never been written.
   task automatic run_op(input bgss_pkg::op_type op, input int x, input int y,
                         input logic [15:0] fx, input logic [15:0] fy,
                         input logic [31:0] v);
      int nx;
      int ny;
      int k;
      int touched;
      int cx [4];
      int cy [4];
      if (op != bgss_pkg::OP_WRITE && x < cols && y < rows) begin
         nx = (x + 1 < cols) ? x + 1 : x;
         ny = (y + 1 < rows) ? y + 1 : y;
         cx = '{x, nx, x, nx};
         cy = '{y, y, ny, ny};
         touched = (op == bgss_pkg::OP_READ) ? 1 : 4;
         for (k = 0; k < touched; k++) begin
            if (!written[(cy[k] * cols + cx[k]) % (GRID_COLUMNS * GRID_ROWS)]) begin
               issue(bgss_pkg::OP_WRITE, cx[k], cy[k], pick_frac(), pick_frac(),
                     pick_value());
            end
         end
      end
      issue(op, x, y, fx, fy, v);
   endtask

   // One random command: mostly in range with the edges favored, some
   // outside the configured size whenever the size leaves room for that.
   task automatic random_item();
      bgss_pkg::op_type op;
      int               x;
      int               y;
      op = bgss_pkg::op_type'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 10 && (cols < GRID_COLUMNS || rows < GRID_ROWS)) begin
         if (cols < GRID_COLUMNS && (rows == GRID_ROWS || $urandom_range(0, 1) == 1)) begin
            x = $urandom_range(cols, COORD_MAX);
            y = $urandom_range(0, COORD_MAX);
         end else begin
            x = $urandom_range(0, COORD_MAX);
            y = $urandom_range(rows, COORD_MAX);
         end
      end else begin
         x = ($urandom_range(0, 4) == 0) ? cols - 1 : $urandom_range(0, cols - 1);
         y = ($urandom_range(0, 4) == 0) ? rows - 1 : $urandom_range(0, rows - 1);
      end
      run_op(op, x, y, pick_frac(), pick_frac(), pick_value());
   endtask

   // Drop start and wait until every expected result word is back, then
   // wait on for the block to go fully idle.
   task automatic settle();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (results_due != 0);
      repeat (12) @(posedge clock);
   endtask

   // One register write; hold valid over back-to-back writes, drop it on the last.
   task automatic csr_write(input logic [1:0] idx, input logic [7:0] data, input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      if (last) begin
         csr_valid <= 1'b0;
      end
      case (idx)
         bgss_pkg::CSR_WIDTH:  cols = eff_dim(data, GRID_COLUMNS);
         bgss_pkg::CSR_HEIGHT: rows = eff_dim(data, GRID_ROWS);
         default:    ;
      endcase
   endtask

   task automatic set_size(input logic [7:0] w, input logic [7:0] h);
      settle();
      csr_write(bgss_pkg::CSR_WIDTH, w, 1'b0);
      csr_write(bgss_pkg::CSR_HEIGHT, h, 1'b1);
   endtask

   initial begin
      int p;
      int n;
      logic [7:0] w_raw;
      logic [7:0] h_raw;

      cols         = GRID_COLUMNS;
      rows         = GRID_ROWS;
      idle_pct     = 0;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_opcode   <= bgss_pkg::OP_WRITE;
      req_x_whole  <= '0;
      req_y_whole  <= '0;
      req_x_frac   <= '0;
      req_y_frac   <= '0;
      req_value_in <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= bgss_pkg::CSR_WIDTH;
      csr_wdata    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset size of 128 x 128.
      // Corner block at full scale: weights at zero, at the top and at half.
      issue(bgss_pkg::OP_WRITE, 0, 0, 16'h0000, 16'h0000, 32'h7FFFFFFF);
      issue(bgss_pkg::OP_WRITE, 1, 0, 16'hFFFF, 16'hFFFF, 32'h7FFFFFFF);
      issue(bgss_pkg::OP_WRITE, 0, 1, 16'h0000, 16'h0000, 32'h7FFFFFFF);
      issue(bgss_pkg::OP_WRITE, 1, 1, 16'h0000, 16'h0000, 32'h7FFFFFFF);
      run_op(bgss_pkg::OP_SAMPLE, 0, 0, 16'h0000, 16'h0000, 32'h0);
      run_op(bgss_pkg::OP_SAMPLE, 0, 0, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
      run_op(bgss_pkg::OP_SAMPLE, 0, 0, 16'h8000, 16'h8000, 32'h0);
      // Far corner at the most negative value; both neighbors clamp there.
      issue(bgss_pkg::OP_WRITE, COORD_MAX, COORD_MAX, 16'h0000, 16'h0000, 32'h80000000);
      run_op(bgss_pkg::OP_READ, COORD_MAX, COORD_MAX, 16'h0000, 16'h0000, 32'h0);
      run_op(bgss_pkg::OP_READ, 0, 0, 16'hFFFF, 16'hFFFF, 32'h0);
      run_op(bgss_pkg::OP_SAMPLE, COORD_MAX, COORD_MAX, 16'hFFFF, 16'hFFFF, 32'h0);
      // Right edge only: the column clamps, the row does not.
      run_op(bgss_pkg::OP_SAMPLE, COORD_MAX, 0, 16'h8000, 16'h4000, 32'h0);
      // Deposits that saturate upward, and downward into one clamped cell.
      run_op(bgss_pkg::OP_DEPOSIT, 0, 0, 16'h8000, 16'h8000, 32'h7FFFFFFF);
      run_op(bgss_pkg::OP_DEPOSIT, COORD_MAX, COORD_MAX, 16'hFFFF, 16'hFFFF, 32'h80000000);
      run_op(bgss_pkg::OP_READ, COORD_MAX, COORD_MAX, 16'h0000, 16'h0000, 32'h0);
      run_op(bgss_pkg::OP_READ, 1, 1, 16'h0000, 16'h0000, 32'h0);
      // Negative delta with all weight on one cell: truncation toward minus infinity.
      run_op(bgss_pkg::OP_DEPOSIT, 5, 5, 16'h0000, 16'h0000, 32'hFFFFFFFF);
      run_op(bgss_pkg::OP_DEPOSIT, 5, 5, 16'h0001, 16'hFFFF, 32'hFFFFFFFF);

      // Zero in both size registers acts as a 1 x 1 grid.
      set_size(8'd0, 8'd0);
      run_op(bgss_pkg::OP_READ, 1, 0, 16'hFFFF, 16'hFFFF, 32'h0);
      run_op(bgss_pkg::OP_WRITE, 0, 1, 16'h0000, 16'h0000, 32'h55AA55AA);
      run_op(bgss_pkg::OP_SAMPLE, COORD_MAX, COORD_MAX, 16'hFFFF, 16'hFFFF, 32'h0);
      run_op(bgss_pkg::OP_DEPOSIT, 5, 0, 16'h1234, 16'h4321, 32'h7FFFFFFF);
      run_op(bgss_pkg::OP_SAMPLE, 0, 0, 16'hFFFF, 16'hFFFF, 32'h0);
      run_op(bgss_pkg::OP_DEPOSIT, 0, 0, 16'hFFFF, 16'h8000, 32'h12345678);
      run_op(bgss_pkg::OP_READ, 0, 0, 16'h0000, 16'h0000, 32'h0);

      // Random phases: each sets a size, then runs with its own sender idling.
      for (p = 0; p < 8; p++) begin
         w_raw = 8'(phase_w[p]);
         h_raw = 8'(phase_h[p]);
         if (p == 6) begin
            w_raw = 8'($urandom_range(0, 255));
            h_raw = 8'($urandom_range(0, 255));
         end
         if (p == 2) begin
            settle();
            csr_write(CSR_SPARE_A, 8'($urandom), 1'b0);
            csr_write(CSR_SPARE_B, 8'($urandom), 1'b1);
         end
         set_size(w_raw, h_raw);
         idle_pct = phase_idle[p];
         for (n = 0; n < phase_len[p]; n++) begin
            random_item();
         end
      end

      settle();
      if (mismatch_count == 0 && results_due == 0) begin
         $display("bilinear_grid_sample_splat_tb: PASS");
      end else begin
         $display("bilinear_grid_sample_splat_tb: FAIL");
      end
      $finish;
   end

endmodule
